// ===== rtl/mwc_pkg.sv =====
`timescale 1ns / 1ps

package mwc_pkg;

    localparam int MAX_TEXT = 1024;
    localparam int ALPHABET = 256;

    localparam int SYM_W   = 8;
    localparam int TXT_AW  = $clog2(MAX_TEXT);
    localparam int CNT_W   = $clog2(MAX_TEXT + 1);
    localparam int SHORT_W = $clog2(ALPHABET + 1);

    localparam logic [CNT_W-1:0] NO_BEST = '1;

    // command carried in the input tuser bit
    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    // one count table word: needed count and count inside the window
    typedef struct packed {
        logic [CNT_W-1:0] need;
        logic [CNT_W-1:0] win;
    } tbl_entry_t;

endpackage

// ===== rtl/min_window_cover.sv =====
`timescale 1ns / 1ps
// Sequence: a pattern transfer reads and rewrites its count-table entry; a text transfer stores
//   the symbol, updates its count and checks the window, then reads the text, reads the count
//   and writes it back for every symbol dropped from the left of the window.
// Throughput: one item at a time; the result is registered at the last check of the query.
// Reset: asynchronous; clears edges, counters, best window and the count-table valid bits, so
//   the count tables read as zero until written. The text buffer is not cleared.
module min_window_cover (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // symbol[7:0]
    input  logic        s_tuser,   // cmd: 0 = pattern, 1 = text
    input  logic        s_tlast,   // last text symbol of the query
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // start_res[9:0], length[20:10], zero[23:21]
    output logic [1:0]  m_tuser    // found[0], overflow[1]
);

    localparam int CNT_W   = mwc_pkg::CNT_W;
    localparam int TXT_AW  = mwc_pkg::TXT_AW;
    localparam int SHORT_W = mwc_pkg::SHORT_W;
    localparam int SYM_W   = mwc_pkg::SYM_W;
    localparam int ALPH    = mwc_pkg::ALPHABET;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PMOD = 3'd1;
    localparam logic [2:0] S_TMOD = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_TXT  = 3'd4;
    localparam logic [2:0] S_SMOD = 3'd5;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(mwc_pkg::MAX_TEXT);

    // memories
    mwc_pkg::tbl_entry_t tbl_mem [ALPH];
    logic [SYM_W-1:0]    txt_mem [mwc_pkg::MAX_TEXT];

    mwc_pkg::tbl_entry_t tbl_rdata_reg;
    logic                tbl_rvalid_reg;
    logic [SYM_W-1:0]    txt_rdata_reg;
    logic [ALPH-1:0]     valid_reg, valid_next;

    logic                tbl_re, tbl_we, txt_we, txt_re;
    logic [SYM_W-1:0]    tbl_raddr, tbl_waddr;
    mwc_pkg::tbl_entry_t tbl_wdata;
    logic [TXT_AW-1:0]   txt_raddr;

    logic [2:0]          state_reg, state_next;
    logic [SYM_W-1:0]    addr_reg, addr_next;
    logic                last_reg, last_next;
    logic [SHORT_W-1:0]  short_reg, short_next;
    logic [CNT_W-1:0]    left_reg, left_next;
    logic [CNT_W-1:0]    right_reg, right_next;
    logic [TXT_AW-1:0]   best_start_reg, best_start_next;
    logic [CNT_W-1:0]    best_len_reg, best_len_next;
    logic                ovf_reg, ovf_next;
    logic                pat_reg, pat_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_found_reg, out_found_next;
    logic [TXT_AW-1:0]   out_start_reg, out_start_next;
    logic [CNT_W-1:0]    out_len_reg, out_len_next;
    logic                out_ovf_reg, out_ovf_next;

    mwc_pkg::tbl_entry_t ent;
    logic [CNT_W-1:0]    need_inc, win_inc, win_dec, win_len;

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re)
        begin
            tbl_rdata_reg  <= tbl_mem[tbl_raddr];
            tbl_rvalid_reg <= valid_reg[tbl_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (txt_we)
        begin
            txt_mem[right_reg[TXT_AW-1:0]] <= s_tdata;
        end
        if (txt_re)
        begin
            txt_rdata_reg <= txt_mem[txt_raddr];
        end
    end

    // an entry never written since the last clear reads as zero
    assign ent      = tbl_rvalid_reg ? tbl_rdata_reg : '0;
    assign need_inc = CNT_W'(ent.need + 1'b1);
    assign win_inc  = CNT_W'(ent.win + 1'b1);
    assign win_dec  = CNT_W'(ent.win - 1'b1);
    assign win_len  = CNT_W'(right_reg - left_reg);

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        last_next       = last_reg;
        short_next      = short_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        ovf_next        = ovf_reg;
        pat_next        = pat_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_found_next  = out_found_reg;
        out_start_next  = out_start_reg;
        out_len_next    = out_len_reg;
        out_ovf_next    = out_ovf_reg;
        valid_next      = valid_reg;
        tbl_re          = 1'b0;
        tbl_raddr       = s_tdata;
        tbl_we          = 1'b0;
        tbl_waddr       = addr_reg;
        tbl_wdata       = ent;
        txt_we          = 1'b0;
        txt_re          = 1'b0;
        txt_raddr       = left_reg[TXT_AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    addr_next = s_tdata;
                    last_next = s_tlast;
                    if (s_tuser == mwc_pkg::CMD_PATTERN)
                    begin
                        tbl_re     = 1'b1;
                        state_next = S_PMOD;
                    end
                    else if (right_reg >= MAX_CNT)
                    begin
                        // text past the buffer: drop the symbol
                        ovf_next   = 1'b1;
                        state_next = S_CHK;
                    end
                    else
                    begin
                        txt_we     = 1'b1;
                        right_next = CNT_W'(right_reg + 1'b1);
                        tbl_re     = 1'b1;
                        state_next = S_TMOD;
                    end
                end
            end
            S_PMOD:
            begin
                if (ent.need >= MAX_CNT)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    tbl_we         = 1'b1;
                    tbl_wdata.need = need_inc;
                    pat_next       = 1'b1;
                    if (!(ent.win < ent.need) && (ent.win < need_inc))
                    begin
                        short_next = SHORT_W'(short_reg + 1'b1);
                    end
                end
                state_next = S_IDLE;
            end
            S_TMOD:
            begin
                if (ent.need != '0)
                begin
                    tbl_we        = 1'b1;
                    tbl_wdata.win = win_inc;
                    if (win_inc == ent.need)
                    begin
                        short_next = SHORT_W'(short_reg - 1'b1);
                    end
                end
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if ((short_reg == '0) && (left_reg < right_reg))
                begin
                    if (win_len < best_len_reg)
                    begin
                        best_len_next   = win_len;
                        best_start_next = left_reg[TXT_AW-1:0];
                    end
                    txt_re     = 1'b1;
                    state_next = S_TXT;
                end
                else if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    // load the result and clear the query
                    out_valid_next  = 1'b1;
                    out_ovf_next    = ovf_reg;
                    if (!pat_reg)
                    begin
                        out_found_next = 1'b1;
                        out_start_next = '0;
                        out_len_next   = '0;
                    end
                    else if (best_len_reg != mwc_pkg::NO_BEST)
                    begin
                        out_found_next = 1'b1;
                        out_start_next = best_start_reg;
                        out_len_next   = best_len_reg;
                    end
                    else
                    begin
                        out_found_next = 1'b0;
                        out_start_next = '0;
                        out_len_next   = '0;
                    end
                    short_next      = '0;
                    left_next       = '0;
                    right_next      = '0;
                    best_start_next = '0;
                    best_len_next   = mwc_pkg::NO_BEST;
                    ovf_next        = 1'b0;
                    pat_next        = 1'b0;
                    valid_next      = '0;
                    state_next      = S_IDLE;
                end
            end
            S_TXT:
            begin
                tbl_re     = 1'b1;
                tbl_raddr  = txt_rdata_reg;
                addr_next  = txt_rdata_reg;
                state_next = S_SMOD;
            end
            S_SMOD:
            begin
                left_next = CNT_W'(left_reg + 1'b1);
                if (ent.need != '0)
                begin
                    if (ent.win == ent.need)
                    begin
                        short_next = SHORT_W'(short_reg + 1'b1);
                    end
                    if (ent.win != '0)
                    begin
                        tbl_we        = 1'b1;
                        tbl_wdata.win = win_dec;
                    end
                end
                state_next = S_CHK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (tbl_we && (state_next != S_IDLE || !last_reg || state_reg != S_CHK))
        begin
            valid_next[tbl_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            last_reg       <= 1'b0;
            short_reg      <= '0;
            left_reg       <= '0;
            right_reg      <= '0;
            best_start_reg <= '0;
            best_len_reg   <= mwc_pkg::NO_BEST;
            ovf_reg        <= 1'b0;
            pat_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            valid_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            last_reg       <= last_next;
            short_reg      <= short_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
            ovf_reg        <= ovf_next;
            pat_reg        <= pat_next;
            out_valid_reg  <= out_valid_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        out_found_reg <= out_found_next;
        out_start_reg <= out_start_next;
        out_len_reg   <= out_len_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_len_reg, out_start_reg};
    assign m_tuser  = {out_ovf_reg, out_found_reg};

    a_edges_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (left_reg <= right_reg) && (right_reg <= MAX_CNT))
        else $error("window edges out of order or past buffer");

    a_no_tbl_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(tbl_we && tbl_re))
        else $error("count table read and write in one cycle");

    a_short_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        short_reg <= SHORT_W'(ALPH))
        else $error("short symbol count out of range");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("no window but nonzero start or length");

    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK && state_next == S_IDLE && last_reg) |=>
        (right_reg == '0 && valid_reg == '0 && m_tvalid))
        else $error("query end did not clear state");

endmodule

// ===== bench/tb_min_window_cover.sv =====
`timescale 1ns / 1ps

module tb_min_window_cover;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int TOTAL_ITEMS = 1650;
    localparam int HOLD_AFTER = 350;
    localparam int HOLD_CYCLES = 600;

    typedef struct {
        bit       cmd;
        bit [7:0] sym;
        bit       last;
        bit       drain;   // hold off until every pending result is back
    } sym_item_t;

    typedef struct {
        bit        found;
        bit [9:0]  start_at;
        bit [10:0] win_len;
        bit        ovf;
    } cover_res_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    min_window_cover dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    sym_item_t  symbol_queue[$];
    cover_res_t cover_q[$];
    sym_item_t  cur_item;
    int         items_done = 0;
    int         errors = 0;
    int         cycles = 0;
    int         gen_items = 0;
    int         gen_queries = 0;

    // shadow of the window search state
    int unsigned need_tbl[mwc_pkg::ALPHABET];
    int unsigned have_tbl[mwc_pkg::ALPHABET];
    bit [7:0]    text_buf[mwc_pkg::MAX_TEXT];
    int unsigned short_cnt;
    int unsigned lo_edge;
    int unsigned hi_edge;
    int unsigned best_at;
    int unsigned best_len;
    bit          sat_flag;

    logic [9:0] hold_left = '0;
    bit         hold_done = 1'b0;
    wire        hold_on = (hold_left != 0);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void clear_search();
        for (int i = 0; i < mwc_pkg::ALPHABET; i++)
        begin
            need_tbl[i] = 0;
            have_tbl[i] = 0;
        end
        short_cnt = 0;
        lo_edge = 0;
        hi_edge = 0;
        best_at = 0;
        best_len = 32'hFFFF_FFFF;
        sat_flag = 1'b0;
    endfunction

    function automatic void note_pattern(bit [7:0] sym);
        bit was_short;
        if (need_tbl[sym] >= mwc_pkg::MAX_TEXT)
        begin
            sat_flag = 1'b1;
            return;
        end
        was_short = have_tbl[sym] < need_tbl[sym];
        need_tbl[sym]++;
        if (!was_short && have_tbl[sym] < need_tbl[sym])
            short_cnt++;
    endfunction

    function automatic void note_text(bit [7:0] sym);
        int unsigned len;
        bit [7:0]    d;
        if (hi_edge >= mwc_pkg::MAX_TEXT)
        begin
            sat_flag = 1'b1;
            return;
        end
        text_buf[hi_edge] = sym;
        hi_edge++;
        if (need_tbl[sym] != 0)
        begin
            have_tbl[sym]++;
            if (have_tbl[sym] == need_tbl[sym])
                short_cnt--;
        end
        // shrink from the left while every needed symbol is still covered
        while (short_cnt == 0 && lo_edge < hi_edge)
        begin
            len = hi_edge - lo_edge;
            if (len < best_len)
            begin
                best_len = len;
                best_at = lo_edge;
            end
            d = text_buf[lo_edge];
            lo_edge++;
            if (need_tbl[d] != 0)
            begin
                if (have_tbl[d] == need_tbl[d])
                    short_cnt++;
                if (have_tbl[d] != 0)
                    have_tbl[d]--;
            end
        end
    endfunction

    function automatic void predict_cover(sym_item_t it);
        cover_res_t r;
        bit         no_pattern;
        if (it.cmd == mwc_pkg::CMD_PATTERN)
        begin
            note_pattern(it.sym);
            return;
        end
        note_text(it.sym);
        if (!it.last)
            return;
        no_pattern = 1'b1;
        for (int i = 0; i < mwc_pkg::ALPHABET; i++)
            if (need_tbl[i] != 0)
                no_pattern = 1'b0;
        r.found = 1'b0;
        r.start_at = '0;
        r.win_len = '0;
        if (no_pattern)
        begin
            r.found = 1'b1;
        end
        else if (best_len != 32'hFFFF_FFFF)
        begin
            r.found = 1'b1;
            r.start_at = best_at[9:0];
            r.win_len = best_len[10:0];
        end
        r.ovf = sat_flag;
        cover_q.push_back(r);
        clear_search();
    endfunction

    function automatic void add_item(bit cmd, bit [7:0] sym, bit last, bit drain);
        sym_item_t it;
        it.cmd = cmd;
        it.sym = sym;
        it.last = last;
        it.drain = drain;
        symbol_queue.push_back(it);
        gen_items++;
    endfunction

    // pattern of np symbols, text of nt symbols, all from [base, base+span)
    // with a few symbols from anywhere and a few out-of-order pattern symbols
    function automatic void add_query(int np, int nt, int base, int span, bit drain);
        bit first;
        first = drain;
        for (int i = 0; i < np; i++)
        begin
            add_item(mwc_pkg::CMD_PATTERN, 8'(base + $urandom_range(0, span - 1)),
                     ($urandom_range(0, 19) == 0), first);
            first = 1'b0;
        end
        for (int i = 0; i < nt; i++)
        begin
            if ($urandom_range(0, 24) == 0)
                add_item(mwc_pkg::CMD_PATTERN, 8'(base + $urandom_range(0, span - 1)),
                         1'($urandom_range(0, 1)), 1'b0);
            if ($urandom_range(0, 9) == 0)
                add_item(mwc_pkg::CMD_TEXT, 8'($urandom_range(0, 255)), (i == nt - 1),
                         first);
            else
                add_item(mwc_pkg::CMD_TEXT, 8'(base + $urandom_range(0, span - 1)),
                         (i == nt - 1), first);
            first = 1'b0;
        end
        gen_queries++;
    endfunction

    function automatic int sender_idle_pct();
        case ((items_done / 150) % 5)
            1: return 72;
            3: return 21;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case ((items_done / 150) % 5)
            2: return 72;
            3: return 21;
            default: return 0;
        endcase
    endfunction

    task automatic check_cover();
        cover_res_t want;
        if (cover_q.size() == 0)
        begin
            if (errors < 10)
                $display("unexpected result: tdata=%h tuser=%b", m_tdata, m_tuser);
            errors++;
            return;
        end
        want = cover_q.pop_front();
        if (m_tuser[0] !== want.found || m_tdata[9:0] !== want.start_at ||
            m_tdata[20:10] !== want.win_len || m_tuser[1] !== want.ovf)
        begin
            if (errors < 10)
                $display("result mismatch: exp found=%0d start=%0d len=%0d ovf=%0d,",
                         want.found, want.start_at, want.win_len, want.ovf,
                         " got found=%0d start=%0d len=%0d ovf=%0d",
                         m_tuser[0], m_tdata[9:0], m_tdata[20:10], m_tuser[1]);
            errors++;
        end
    endtask

    // driver: present the next item once the current transfer is done
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
            s_tlast <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_cover(cur_item);
                items_done++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (symbol_queue.size() != 0 &&
                    !(symbol_queue[0].drain && cover_q.size() != 0) &&
                    $urandom_range(0, 99) >= sender_idle_pct())
                begin
                    cur_item = symbol_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= cur_item.sym;
                    s_tuser <= cur_item.cmd;
                    s_tlast <= cur_item.last;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_cover();
            m_tready <= !hold_on && ($urandom_range(0, 99) >= receiver_stall_pct());
        end
    end

    // one long receiver hold-off so the block backs up into its input
    always @(posedge clk)
    begin
        if (!hold_done && items_done >= HOLD_AFTER)
        begin
            hold_done <= 1'b1;
            hold_left <= 10'(HOLD_CYCLES);
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** min_window_cover: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int kind;
        int span;
        int np;
        int nt;

        clear_search();

        // empty pattern
        add_item(mwc_pkg::CMD_TEXT, 8'h00, 1'b1, 1'b0);
        // extremes of the symbol range, last on a pattern symbol is ignored
        add_item(mwc_pkg::CMD_PATTERN, 8'h00, 1'b0, 1'b0);
        add_item(mwc_pkg::CMD_PATTERN, 8'hFF, 1'b1, 1'b0);
        add_item(mwc_pkg::CMD_TEXT, 8'hFF, 1'b0, 1'b0);
        add_item(mwc_pkg::CMD_TEXT, 8'h12, 1'b0, 1'b0);
        add_item(mwc_pkg::CMD_TEXT, 8'h00, 1'b1, 1'b0);
        // repeated pattern symbol never covered
        add_item(mwc_pkg::CMD_PATTERN, 8'h61, 1'b0, 1'b1);
        add_item(mwc_pkg::CMD_PATTERN, 8'h61, 1'b0, 1'b0);
        add_item(mwc_pkg::CMD_TEXT, 8'h61, 1'b1, 1'b0);
        // pattern symbol arriving after text
        add_item(mwc_pkg::CMD_PATTERN, 8'h62, 1'b0, 1'b0);
        add_item(mwc_pkg::CMD_TEXT, 8'h78, 1'b0, 1'b0);
        add_item(mwc_pkg::CMD_TEXT, 8'h62, 1'b0, 1'b0);
        add_item(mwc_pkg::CMD_TEXT, 8'h79, 1'b0, 1'b0);
        add_item(mwc_pkg::CMD_PATTERN, 8'h62, 1'b0, 1'b0);
        add_item(mwc_pkg::CMD_TEXT, 8'h62, 1'b0, 1'b0);
        add_item(mwc_pkg::CMD_TEXT, 8'h63, 1'b0, 1'b0);
        add_item(mwc_pkg::CMD_TEXT, 8'h62, 1'b1, 1'b0);
        // tie between two shortest windows: earliest wins
        add_item(mwc_pkg::CMD_PATTERN, 8'h80, 1'b0, 1'b0);
        add_item(mwc_pkg::CMD_PATTERN, 8'h7F, 1'b0, 1'b0);
        add_item(mwc_pkg::CMD_TEXT, 8'h80, 1'b0, 1'b0);
        add_item(mwc_pkg::CMD_TEXT, 8'h7F, 1'b0, 1'b0);
        add_item(mwc_pkg::CMD_TEXT, 8'h80, 1'b1, 1'b0);

        // random queries, leaving room for the long text at the end
        while (gen_items < TOTAL_ITEMS - mwc_pkg::MAX_TEXT - 8)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                // noise: anything from the full symbol range
                add_query($urandom_range(0, 3), $urandom_range(1, 8), 0, 256,
                          (gen_queries % 25 == 0));
            end
            else
            begin
                span = $urandom_range(1, 6);
                np = $urandom_range(0, 4);
                nt = ($urandom_range(0, 39) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(1, 20);
                add_query(np, nt, $urandom_range(0, 256 - span), span,
                          (gen_queries % 25 == 0));
            end
        end

        // text longer than the buffer
        add_query(2, mwc_pkg::MAX_TEXT + 6, $urandom_range(0, 252), 3, 1'b1);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (symbol_queue.size() != 0 || s_tvalid)
            @(posedge clk);
        while (cover_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (errors == 0)
            $display("** min_window_cover: PASSED **");
        else
            $display("** min_window_cover: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mwc_pkg.sv
rtl/min_window_cover.sv
bench/tb_min_window_cover.sv
